// ===== sv/x10pe_pkg.sv =====
`default_nettype none

package x10pe_pkg;

  localparam int unsigned FrameW = 32;
  localparam int unsigned WidthW = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 4;

  localparam int unsigned LeadN = 5;
  localparam int unsigned FrameItems = LeadN + FrameW + 1;
  localparam int unsigned LastIdx = FrameItems - 1;
  localparam int unsigned CntW = $clog2(FrameItems);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam logic [WidthW-1:0] PwShort = 8'd59;
  localparam logic [WidthW-1:0] PwLong = 8'd169;
  localparam logic [WidthW-1:0] PwNone = 8'd0;

  localparam logic [CfgIdxW-1:0] RegHouseLetter = 4'd0;
  localparam logic [CfgIdxW-1:0] RegUnitIndex = 4'd1;

  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] frame;
  } frm_req_t;

  function automatic logic [3:0] house_code(input logic [3:0] letter);
    logic [3:0] code;
    case (letter)
      4'd0: code = 4'h6;
      4'd1: code = 4'hE;
      4'd2: code = 4'h2;
      4'd3: code = 4'hA;
      4'd4: code = 4'h1;
      4'd5: code = 4'h9;
      4'd6: code = 4'h5;
      4'd7: code = 4'hD;
      4'd8: code = 4'h7;
      4'd9: code = 4'hF;
      4'd10: code = 4'h3;
      4'd11: code = 4'hB;
      4'd12: code = 4'h0;
      4'd13: code = 4'h8;
      4'd14: code = 4'h4;
      4'd15: code = 4'hC;
      default: code = 4'h6;
    endcase
    return code;
  endfunction

  function automatic logic [WidthW-1:0] lead_first(input logic [2:0] idx);
    logic [WidthW-1:0] w;
    case (idx)
      3'd0, 3'd1, 3'd2: w = 8'd255;
      3'd3: w = 8'd100;
      3'd4: w = 8'd1;
      default: w = 8'd255;
    endcase
    return w;
  endfunction

  function automatic logic [WidthW-1:0] lead_second(input logic [2:0] idx);
    logic [WidthW-1:0] w;
    case (idx)
      3'd0, 3'd1, 3'd2: w = 8'd1;
      3'd3: w = 8'd255;
      3'd4: w = 8'd180;
      default: w = 8'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/x10pe_front.sv =====
`default_nettype none

module x10pe_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [x10pe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [x10pe_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                            cmd_valid_i,
  input  wire logic                            turn_on_i,
  output x10pe_pkg::frm_req_t                  frm_o
);

  logic [3:0] house_letter_q, house_letter_d;
  logic [3:0] unit_index_q, unit_index_d;
  logic [3:0] hc;
  logic [7:0] b1, b2;

  always_comb begin
    house_letter_d = house_letter_q;
    unit_index_d = unit_index_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        x10pe_pkg::RegHouseLetter: house_letter_d = cfg_data_i;
        x10pe_pkg::RegUnitIndex: unit_index_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      house_letter_q <= '0;
      unit_index_q <= '0;
    end else begin
      house_letter_q <= house_letter_d;
      unit_index_q <= unit_index_d;
    end
  end

  // The first bit sent sits in bit 7 of each byte.
  always_comb begin
    hc = x10pe_pkg::house_code(house_letter_q);
    b1 = {hc[0], hc[1], hc[2], hc[3], 1'b0, unit_index_q[3], 2'b00};
    b2 = {1'b0, unit_index_q[2], ~turn_on_i, unit_index_q[0], unit_index_q[1], 3'b000};
    frm_o.valid = cmd_valid_i;
    frm_o.frame = {b1, ~b1, b2, ~b2};
  end

endmodule

`default_nettype wire

// ===== sv/x10pe_queue.sv =====
`default_nettype none

module x10pe_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire x10pe_pkg::frm_req_t           wr_i,
  output logic                               full_o,
  output x10pe_pkg::frm_req_t                head_o,
  input  wire logic                          pop_i
);

  logic [x10pe_pkg::FrameW-1:0] mem_q [x10pe_pkg::QDepth];
  logic [x10pe_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [x10pe_pkg::QCntW-1:0]  count_q, count_d;
  logic                         do_wr, do_rd;

  assign full_o = (count_q == x10pe_pkg::QCntW'(x10pe_pkg::QDepth));
  assign do_wr = wr_i.valid && !full_o;
  assign do_rd = pop_i && head_o.valid;
  assign head_o.valid = (count_q != '0);
  assign head_o.frame = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + x10pe_pkg::QCntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - x10pe_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + x10pe_pkg::QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + x10pe_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.frame;
    end
  end

endmodule

`default_nettype wire

// ===== sv/x10pe_back.sv =====
`default_nettype none

module x10pe_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire x10pe_pkg::frm_req_t             head_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_pop_i,
  output logic [x10pe_pkg::WidthW-1:0]         first_width_o,
  output logic [x10pe_pkg::WidthW-1:0]         second_width_o,
  output logic                                 last_o
);

  logic                         busy_q;
  logic [x10pe_pkg::CntW-1:0]   cnt_q;
  logic [x10pe_pkg::FrameW-1:0] frame_q;
  logic                         out_valid_q;
  logic [x10pe_pkg::WidthW-1:0] first_q, first_d;
  logic [x10pe_pkg::WidthW-1:0] second_q, second_d;
  logic                         last_q, last_d;
  logic                         adv, take_item, at_last, is_lead, is_data;

  assign adv = !out_valid_q || out_pop_i;
  assign take_item = busy_q && adv;
  assign at_last = (cnt_q == x10pe_pkg::CntW'(x10pe_pkg::LastIdx));
  assign is_lead = (cnt_q < x10pe_pkg::CntW'(x10pe_pkg::LeadN));
  assign is_data = !is_lead && !at_last;
  assign q_pop_o = head_i.valid && (!busy_q || (take_item && at_last));

  always_comb begin
    if (is_lead) begin
      first_d = x10pe_pkg::lead_first(cnt_q[2:0]);
      second_d = x10pe_pkg::lead_second(cnt_q[2:0]);
      last_d = 1'b0;
    end else if (at_last) begin
      first_d = x10pe_pkg::PwShort;
      second_d = x10pe_pkg::PwNone;
      last_d = 1'b1;
    end else begin
      first_d = x10pe_pkg::PwShort;
      second_d = frame_q[x10pe_pkg::FrameW-1] ? x10pe_pkg::PwLong : x10pe_pkg::PwShort;
      last_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (take_item && at_last) begin
        busy_q <= 1'b0;
        cnt_q <= '0;
      end else if (take_item) begin
        cnt_q <= cnt_q + x10pe_pkg::CntW'(1);
      end
      if (adv) begin
        out_valid_q <= take_item;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      frame_q <= head_i.frame;
    end else if (take_item && is_data) begin
      frame_q <= {frame_q[x10pe_pkg::FrameW-2:0], 1'b0};
    end
    if (take_item) begin
      first_q <= first_d;
      second_q <= second_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign first_width_o = first_q;
  assign second_width_o = second_q;
  assign last_o = last_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= x10pe_pkg::CntW'(x10pe_pkg::LastIdx))
    else $error("symbol counter out of range");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0)
    else $error("symbol counter not cleared while idle");

  a_stop_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_item && at_last |=> out_valid_q && last_q)
    else $error("stop pulse not presented");
`endif

endmodule

`default_nettype wire

// ===== sv/x10_rf_pulse_encoder_unit.sv =====
// X10 radio on/off frame encoder.
// Commands enter through push/full: turn_on_i is taken at an edge with push high
// and full low. Each command yields 38 pulse-width pairs, read through empty/pop:
// five start pairs, 32 data bits and one stop pulse flagged by last_o.
// The house letter and unit index registers are written through the cfg_*
// channel, which is always ready; write them only while no frame is in flight.
// The first pair of a frame passes through the frame queue, the sequencer and
// its output register before it is on the result ports. The back-end symbol
// sequencer gives one pair per cycle while pop takes each pair. A two-entry
// frame queue sits between the command side and the sequencer, so up to two
// further commands are taken while a frame is being sent.
// When pop stays low, the held pair waits on the ports and the sequencer stops;
// commands keep being accepted until the frame queue is full.
// Reset selects house A, unit 1, and empties the queue and the output register.
`default_nettype none

module x10_rf_pulse_encoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            turn_on_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [x10pe_pkg::WidthW-1:0]         first_width_o,
  output logic [x10pe_pkg::WidthW-1:0]         second_width_o,
  output logic                                 last_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [x10pe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [x10pe_pkg::CfgDataW-1:0]  cfg_data_i
);

  x10pe_pkg::frm_req_t wr_req, head;
  logic                q_full, q_pop, out_valid;

  assign cfg_ready_o = 1'b1;
  assign full = q_full;
  assign empty = !out_valid;

  x10pe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (push),
    .turn_on_i   (turn_on_i),
    .frm_o       (wr_req)
  );

  x10pe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr_req),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (q_pop)
  );

  x10pe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid),
    .out_pop_i      (pop),
    .first_width_o  (first_width_o),
    .second_width_o (second_width_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
